### src/psp_pkg.sv
// Shared types, codes and constants of the pressure sensor poller.
`default_nettype none

package psp_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int DATA_W     = 48;
	localparam int CMD_W      = 3;
	localparam int STAGE_W    = 3;
	localparam int PRESS_W    = 18;
	localparam int PRESS10_W  = 15;
	localparam int TEMP_W     = 13;
	localparam int TLIM_W     = 12;
	localparam int BYTE_W     = 8;
	localparam int RETRY_W    = 6;
	localparam int CFG_W      = 18;
	localparam int CFG_IDX_W  = 3;

	localparam logic [RETRY_W-1:0] RETRY_LIMIT = 6'd50;
	localparam logic [RETRY_W-1:0] RETRY_SAT   = 6'd63;

	localparam logic [BYTE_W-1:0] HOLD_KNOCK  = 8'd5;
	localparam logic [BYTE_W-1:0] HOLD_INIT   = 8'd10;
	localparam logic [BYTE_W-1:0] HOLD_STATUS = 8'd50;

	// Reciprocals for division by constants: floor(x * M / 2^K) is exact over the input range.
	localparam logic [24:0] TEMP_RECIP   = 25'd20970241; // 2^37 / 6554, rounded up
	localparam int          TEMP_SHIFT   = 37;
	localparam logic [17:0] PRESS_RECIP  = 18'd209716;   // 2^21 / 10, rounded up
	localparam int          PRESS_SHIFT  = 21;

	// Reset values of the configuration registers
	localparam logic [BYTE_W-1:0]        RST_CHIP_ID   = 8'hA0;
	localparam logic [BYTE_W-1:0]        RST_READY     = 8'h60;
	localparam logic [PRESS_W-1:0]       RST_PRESS_MIN = 18'd30000;
	localparam logic [PRESS_W-1:0]       RST_PRESS_MAX = 18'd125000;
	localparam logic signed [TLIM_W-1:0] RST_TEMP_MIN  = -12'sd400;
	localparam logic signed [TLIM_W-1:0] RST_TEMP_MAX  = 12'sd850;
	localparam logic [BYTE_W-1:0]        RST_HOLD      = 8'd200;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_TICK = 2'd0,
		REQ_POLL = 2'd1,
		REQ_RESP = 2'd2,
		REQ_RSVD = 2'd3
	} req_kind_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE     = 3'd0,
		CMD_BUSINIT  = 3'd1,
		CMD_READID   = 3'd2,
		CMD_SETUP    = 3'd3,
		CMD_STATUS   = 3'd4,
		CMD_READDATA = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHIP_ID   = 3'd0,
		CFG_READY     = 3'd1,
		CFG_PRESS_MIN = 3'd2,
		CFG_PRESS_MAX = 3'd3,
		CFG_TEMP_MIN  = 3'd4,
		CFG_TEMP_MAX  = 3'd5,
		CFG_HOLD      = 3'd6,
		CFG_CLAMP     = 3'd7
	} cfg_idx_t;

	// Stage codes as seen on the result channel
	localparam logic [STAGE_W-1:0] STG_UNINIT = 3'd0;
	localparam logic [STAGE_W-1:0] STG_KNOCK  = 3'd1;
	localparam logic [STAGE_W-1:0] STG_INIT   = 3'd2;
	localparam logic [STAGE_W-1:0] STG_WAIT   = 3'd3;
	localparam logic [STAGE_W-1:0] STG_DATA   = 3'd4;

	typedef enum logic [4:0] {
		ST_UNINIT = 5'b00001,
		ST_KNOCK  = 5'b00010,
		ST_INIT   = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_DATA   = 5'b10000
	} stage_t;

	function automatic logic [STAGE_W-1:0] stage_code(input stage_t st);
		logic [STAGE_W-1:0] code;
		case (st)
			ST_UNINIT: code = STG_UNINIT;
			ST_KNOCK:  code = STG_KNOCK;
			ST_INIT:   code = STG_INIT;
			ST_WAIT:   code = STG_WAIT;
			ST_DATA:   code = STG_DATA;
			default:   code = STG_UNINIT;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

### src/psp_if.sv
// Request and result channel interfaces of the pressure sensor poller.
`default_nettype none

interface psp_req_if;
	import psp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic                  bus_ok;
	logic [DATA_W-1:0]     read_data;

	modport source (output valid, output req_type, output bus_ok, output read_data,
		input ready);
	modport sink (input valid, input req_type, input bus_ok, input read_data,
		output ready);
endinterface

interface psp_res_if;
	import psp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [STAGE_W-1:0]       stage;
	logic [PRESS_W-1:0]       pressure_pa;
	logic [PRESS10_W-1:0]     pressure_10pa;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic                     comm_error;
	logic                     temp_range_error;
	logic                     press_range_error;

	modport source (output valid, output command, output stage, output pressure_pa,
		output pressure_10pa, output temperature_tenths, output comm_error,
		output temp_range_error, output press_range_error, input ready);
	modport sink (input valid, input command, input stage, input pressure_pa,
		input pressure_10pa, input temperature_tenths, input comm_error,
		input temp_range_error, input press_range_error, output ready);
endinterface

`default_nettype wire

### src/pressure_sensor_poller.sv
// Polling sequencer for a pressure and temperature sensor.
//
// Usage:
//   req  - request channel: a tick (counts the hold timer down), a poll (acts on the
//          current stage and may issue one bus command) or a bus response (completes
//          the outstanding command; a data read carries pressure and temperature).
//   res  - one result per request: the command issued by that request, the stage
//          after it, the last latched pressure (Pa and 10 Pa) and temperature
//          (0.1 degree), and the communication and range error flags.
//   cfg_we/cfg_index/cfg_wdata - register writes; change them only while idle.
// Path: an accepted request passes the input register, then the state update into the
//   result, when the result side is free.
// Throughput: one request per cycle while the result side is free; every request is a
//   single state update, so the update loop through the sequencer state sets the rate.
// Reset (arst_n low): stage uninit, hold, retry, latches and flags cleared,
//   no command outstanding, registers back to their defaults, both channels empty.
// Stall: while res.ready is low the result holds; one more request is taken
//   into the input register, then req.ready drops until the result leaves.
`default_nettype none

module pressure_sensor_poller (
	input  logic                               clk,
	input  logic                               arst_n,
	psp_req_if.sink                            req,
	psp_res_if.source                          res,
	input  logic                               cfg_we,
	input  psp_pkg::cfg_idx_t                  cfg_index,
	input  logic [psp_pkg::CFG_W-1:0]          cfg_wdata
);
	import psp_pkg::*;

	// Configuration registers
	logic [BYTE_W-1:0]        chip_id_q;
	logic [BYTE_W-1:0]        ready_status_q;
	logic [PRESS_W-1:0]       press_min_q;
	logic [PRESS_W-1:0]       press_max_q;
	logic signed [TLIM_W-1:0] temp_min_q;
	logic signed [TLIM_W-1:0] temp_max_q;
	logic [BYTE_W-1:0]        sample_hold_q;
	logic                     clamp_en_q;

	// Input register
	logic                  valid_s1;
	logic [REQ_TYPE_W-1:0] req_type_s1;
	logic                  bus_ok_s1;
	logic [DATA_W-1:0]     read_data_s1;

	// Sequencer state; the latches and flags double as the result payload
	stage_t                   stage_q, stage_d;
	logic [BYTE_W-1:0]        hold_q, hold_d;
	logic [RETRY_W-1:0]       retry_q, retry_d;
	cmd_t                     await_q, await_d;
	logic [PRESS_W-1:0]       press_q, press_d;
	logic [PRESS10_W-1:0]     press10_q, press10_d;
	logic signed [TEMP_W-1:0] temp_q, temp_d;
	logic                     comm_err_q, comm_err_d;
	logic                     temp_err_q, temp_err_d;
	logic                     press_err_q, press_err_d;
	cmd_t                     cmd_q, cmd_d;
	logic                     out_valid_q;

	logic advance;
	logic take_in;

	// Data path of a data read
	logic [PRESS_W-1:0]       p_raw;
	logic                     p_lo, p_hi;
	logic [PRESS_W-1:0]       p_new;
	logic [35:0]              p_prod;
	logic [23:0]              t_raw;
	logic [48:0]              t_prod;
	logic [TLIM_W-1:0]        t_quo;
	logic signed [TEMP_W-1:0] t_val, t_min, t_max, t_new;
	logic                     t_lo, t_hi;

	logic [RETRY_W-1:0] retry_inc;
	logic [BYTE_W-1:0]  byte0;

	// Process the held request when the result slot is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign take_in   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_id_q      <= RST_CHIP_ID;
			ready_status_q <= RST_READY;
			press_min_q    <= RST_PRESS_MIN;
			press_max_q    <= RST_PRESS_MAX;
			temp_min_q     <= RST_TEMP_MIN;
			temp_max_q     <= RST_TEMP_MAX;
			sample_hold_q  <= RST_HOLD;
			clamp_en_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHIP_ID:   chip_id_q      <= cfg_wdata[BYTE_W-1:0];
				CFG_READY:     ready_status_q <= cfg_wdata[BYTE_W-1:0];
				CFG_PRESS_MIN: press_min_q    <= cfg_wdata[PRESS_W-1:0];
				CFG_PRESS_MAX: press_max_q    <= cfg_wdata[PRESS_W-1:0];
				CFG_TEMP_MIN:  temp_min_q     <= cfg_wdata[TLIM_W-1:0];
				CFG_TEMP_MAX:  temp_max_q     <= cfg_wdata[TLIM_W-1:0];
				CFG_HOLD:      sample_hold_q  <= cfg_wdata[BYTE_W-1:0];
				CFG_CLAMP:     clamp_en_q     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the request until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_type_s1  <= req.req_type;
			bus_ok_s1    <= req.bus_ok;
			read_data_s1 <= req.read_data;
		end
	end

	// Pressure: bits 23:6 of the low three bytes, checked against the window
	assign p_raw  = read_data_s1[23:6];
	assign p_lo   = p_raw < press_min_q;
	assign p_hi   = p_raw > press_max_q;
	always_comb begin
		p_new = p_raw;
		if (clamp_en_q && p_lo) begin
			p_new = press_min_q;
		end else if (clamp_en_q && p_hi) begin
			p_new = press_max_q;
		end
	end
	assign p_prod = 36'(p_new) * 36'(PRESS_RECIP);

	// Temperature: upper three bytes divided by 6554 (quotient fits 12 bits unsigned)
	assign t_raw  = read_data_s1[47:24];
	assign t_prod = 49'(t_raw) * 49'(TEMP_RECIP);
	assign t_quo  = t_prod[TEMP_SHIFT +: TLIM_W];
	assign t_val  = signed'({1'b0, t_quo});
	assign t_min  = TEMP_W'(temp_min_q);
	assign t_max  = TEMP_W'(temp_max_q);
	assign t_lo   = t_val < t_min;
	assign t_hi   = t_val > t_max;
	always_comb begin
		t_new = t_val;
		if (clamp_en_q && t_lo) begin
			t_new = t_min;
		end else if (clamp_en_q && t_hi) begin
			t_new = t_max;
		end
	end

	assign retry_inc = (retry_q == RETRY_SAT) ? retry_q : retry_q + 1'b1;
	assign byte0     = read_data_s1[BYTE_W-1:0];

	// Next state of the sequencer for the held request
	always_comb begin
		stage_d     = stage_q;
		hold_d      = hold_q;
		retry_d     = retry_q;
		await_d     = await_q;
		press_d     = press_q;
		press10_d   = press10_q;
		temp_d      = temp_q;
		comm_err_d  = comm_err_q;
		temp_err_d  = temp_err_q;
		press_err_d = press_err_q;
		cmd_d       = CMD_NONE;

		case (req_kind_t'(req_type_s1))
			REQ_TICK: begin
				if (hold_q != '0) begin
					hold_d = hold_q - 1'b1;
				end
			end
			REQ_POLL: begin
				if (await_q == CMD_NONE) begin
					if (stage_q == ST_UNINIT) begin
						// Bus init needs no response; clear range flags
						stage_d     = ST_KNOCK;
						hold_d      = HOLD_KNOCK;
						comm_err_d  = 1'b1;
						temp_err_d  = 1'b0;
						press_err_d = 1'b0;
						cmd_d       = CMD_BUSINIT;
					end else if (hold_q == '0) begin
						case (stage_q)
							ST_KNOCK: cmd_d = CMD_READID;
							ST_INIT:  cmd_d = CMD_SETUP;
							ST_WAIT:  cmd_d = CMD_STATUS;
							ST_DATA:  cmd_d = CMD_READDATA;
							default:  cmd_d = CMD_NONE;
						endcase
						await_d = cmd_d;
					end
				end
			end
			REQ_RESP: begin
				if (await_q != CMD_NONE) begin
					await_d = CMD_NONE;
					case (await_q)
						CMD_READID: begin
							if (bus_ok_s1 && byte0 == chip_id_q) begin
								stage_d    = ST_INIT;
								hold_d     = HOLD_INIT;
								comm_err_d = 1'b0;
							end else begin
								stage_d    = ST_UNINIT;
								comm_err_d = 1'b1;
							end
						end
						CMD_SETUP: begin
							if (bus_ok_s1) begin
								stage_d    = ST_WAIT;
								hold_d     = HOLD_STATUS;
								retry_d    = '0;
								comm_err_d = 1'b0;
							end else begin
								stage_d    = ST_UNINIT;
								hold_d     = HOLD_INIT;
								comm_err_d = 1'b1;
							end
						end
						CMD_STATUS: begin
							if (bus_ok_s1 && byte0 == ready_status_q) begin
								stage_d = ST_DATA;
								hold_d  = '0;
								retry_d = '0;
							end else begin
								// Not ready: re-knock once retries run past the limit
								hold_d = HOLD_STATUS;
								if (retry_inc > RETRY_LIMIT) begin
									stage_d = ST_KNOCK;
									retry_d = '0;
								end else begin
									retry_d = retry_inc;
								end
							end
						end
						CMD_READDATA: begin
							retry_d = '0;
							if (bus_ok_s1) begin
								press_d     = p_new;
								press10_d   = p_prod[PRESS_SHIFT +: PRESS10_W];
								press_err_d = p_lo || p_hi;
								temp_d      = t_new;
								temp_err_d  = t_lo || t_hi;
								comm_err_d  = 1'b0;
								stage_d     = ST_WAIT;
								hold_d      = sample_hold_q;
							end else begin
								comm_err_d = 1'b1;
								if (retry_inc > RETRY_LIMIT) begin
									stage_d = ST_INIT;
									hold_d  = HOLD_INIT;
								end else begin
									stage_d = ST_WAIT;
									hold_d  = sample_hold_q;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and result: advance together, one request per cycle while the result slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_UNINIT;
			hold_q      <= '0;
			retry_q     <= '0;
			await_q     <= CMD_NONE;
			press_q     <= '0;
			press10_q   <= '0;
			temp_q      <= '0;
			comm_err_q  <= 1'b0;
			temp_err_q  <= 1'b0;
			press_err_q <= 1'b0;
			cmd_q       <= CMD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				stage_q     <= stage_d;
				hold_q      <= hold_d;
				retry_q     <= retry_d;
				await_q     <= await_d;
				press_q     <= press_d;
				press10_q   <= press10_d;
				temp_q      <= temp_d;
				comm_err_q  <= comm_err_d;
				temp_err_q  <= temp_err_d;
				press_err_q <= press_err_d;
				cmd_q       <= cmd_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid              = out_valid_q;
	assign res.command            = cmd_q;
	assign res.stage              = stage_code(stage_q);
	assign res.pressure_pa        = press_q;
	assign res.pressure_10pa      = press10_q;
	assign res.temperature_tenths = temp_q;
	assign res.comm_error         = comm_err_q;
	assign res.temp_range_error   = temp_err_q;
	assign res.press_range_error  = press_err_q;

endmodule

`default_nettype wire

### src/psp_checker.sv
// Port-level assertions for the pressure sensor poller, bound to the top level.
`default_nettype none

module psp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [psp_pkg::CMD_W-1:0]         res_command,
	input logic [psp_pkg::STAGE_W-1:0]       res_stage,
	input logic [psp_pkg::PRESS_W-1:0]       res_pressure_pa,
	input logic [psp_pkg::PRESS10_W-1:0]     res_pressure_10pa,
	input logic                              res_comm_error,
	input logic                              res_temp_range_error,
	input logic                              res_press_range_error
);
	import psp_pkg::*;

	// A stalled result holds its command and stage
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_command) && $stable(res_stage))
		else $error("result changed while stalled");

	// Every issued command matches the stage it leaves the sequencer in
	a_cmd_stage: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_command != CMD_NONE |->
			((res_command == CMD_BUSINIT  && res_stage == STG_KNOCK) ||
			 (res_command == CMD_READID   && res_stage == STG_KNOCK) ||
			 (res_command == CMD_SETUP    && res_stage == STG_INIT)  ||
			 (res_command == CMD_STATUS   && res_stage == STG_WAIT)  ||
			 (res_command == CMD_READDATA && res_stage == STG_DATA)))
		else $error("command does not match stage");

	// The 10 Pa value tracks the pascal value: ten times it lies within 10 Pa below
	a_press10: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(19'(res_pressure_10pa) * 19'd10 <= 19'(res_pressure_pa)) &&
			(19'(res_pressure_pa) < 19'(res_pressure_10pa) * 19'd10 + 19'd10))
		else $error("pressure in 10 Pa does not match pressure in Pa");

	// Bus init raises the comm flag and clears the range flags
	a_businit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_command == CMD_BUSINIT |->
			res_comm_error && !res_temp_range_error && !res_press_range_error)
		else $error("flags wrong after bus init");

endmodule

bind pressure_sensor_poller psp_checker u_psp_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.res_valid             (res.valid),
	.res_ready             (res.ready),
	.res_command           (res.command),
	.res_stage             (res.stage),
	.res_pressure_pa       (res.pressure_pa),
	.res_pressure_10pa     (res.pressure_10pa),
	.res_comm_error        (res.comm_error),
	.res_temp_range_error  (res.temp_range_error),
	.res_press_range_error (res.press_range_error)
);

`default_nettype wire

### dv/pressure_sensor_poller_test.sv
// Self-checking testbench of the pressure sensor poller: directed bring-up, windows, retries, random.
`timescale 1ns / 1ps

module pressure_sensor_poller_test;
	import psp_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 10;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_REQUESTS = 130;

	// One result of the block, packed so that a whole record compares with !==
	typedef struct packed {
		cmd_t                     cmd;
		logic [STAGE_W-1:0]       stage;
		logic [PRESS_W-1:0]       press;
		logic [PRESS10_W-1:0]     press10;
		logic signed [TEMP_W-1:0] temp;
		logic                     comm;
		logic                     terr;
		logic                     perr;
	} poll_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	psp_req_if req_ch ();
	psp_res_if res_ch ();

	pressure_sensor_poller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Sequencer mirror: stage, timers, outstanding command, latches and flags
	logic [STAGE_W-1:0]       sq_stage;
	logic [BYTE_W-1:0]        sq_hold;
	logic [RETRY_W-1:0]       sq_retry;
	cmd_t                     sq_pending;
	logic [PRESS_W-1:0]       sq_press;
	logic signed [TEMP_W-1:0] sq_temp;
	logic                     sq_comm, sq_terr, sq_perr;

	// Register mirror
	logic [BYTE_W-1:0]        cf_chip_id, cf_ready, cf_hold;
	logic [PRESS_W-1:0]       cf_pmin, cf_pmax;
	logic signed [TLIM_W-1:0] cf_tmin, cf_tmax;
	logic                     cf_clamp;

	poll_result_t predicted_results[$];

	int mismatch_count = 0;
	int requests_sent  = 0;
	int results_seen   = 0;
	int sample_reads   = 0;
	int reknocks       = 0;
	int reg_writes     = 0;
	int cycle_count    = 0;

	// Sender and receiver idling controls
	bit gaps_on  = 1'b0;
	bit stall_on = 1'b0;
	int burst_left = 0;
	int stall_left = 0;
	int run_left   = 0;
	int noise_pct  = 15;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void clear_sequencer();
		sq_stage   = STG_UNINIT;
		sq_hold    = '0;
		sq_retry   = '0;
		sq_pending = CMD_NONE;
		sq_press   = '0;
		sq_temp    = '0;
		sq_comm    = 1'b0;
		sq_terr    = 1'b0;
		sq_perr    = 1'b0;
		cf_chip_id = RST_CHIP_ID;
		cf_ready   = RST_READY;
		cf_pmin    = RST_PRESS_MIN;
		cf_pmax    = RST_PRESS_MAX;
		cf_tmin    = RST_TEMP_MIN;
		cf_tmax    = RST_TEMP_MAX;
		cf_hold    = RST_HOLD;
		cf_clamp   = 1'b1;
	endfunction

	function automatic void bump_retry();
		if (sq_retry < RETRY_SAT)
			sq_retry = sq_retry + 1'b1;
	endfunction

	// Latch pressure and temperature from a good data read, flag them and, with clamping on, clamp to the windows
	function automatic void latch_sample(input logic [DATA_W-1:0] data);
		logic [PRESS_W-1:0] p;
		int t, lo, hi;
		p  = data[23:6];
		t  = data[47:24] / 6554;
		lo = cf_tmin;
		hi = cf_tmax;
		// below-min test wins when the window is inverted
		if (p < cf_pmin) begin
			if (cf_clamp)
				p = cf_pmin;
			sq_perr = 1'b1;
		end else if (p > cf_pmax) begin
			if (cf_clamp)
				p = cf_pmax;
			sq_perr = 1'b1;
		end else begin
			sq_perr = 1'b0;
		end
		sq_press = p;
		if (t < lo) begin
			if (cf_clamp)
				t = lo;
			sq_terr = 1'b1;
		end else if (t > hi) begin
			if (cf_clamp)
				t = hi;
			sq_terr = 1'b1;
		end else begin
			sq_terr = 1'b0;
		end
		sq_temp = TEMP_W'(t);
	endfunction

	function automatic cmd_t issue_poll();
		if (sq_pending != CMD_NONE)
			return CMD_NONE;
		// uninit kicks the bus regardless of the hold timer
		if (sq_stage == STG_UNINIT) begin
			sq_stage = STG_KNOCK;
			sq_hold  = HOLD_KNOCK;
			sq_comm  = 1'b1;
			sq_terr  = 1'b0;
			sq_perr  = 1'b0;
			return CMD_BUSINIT;
		end
		if (sq_hold != 0)
			return CMD_NONE;
		case (sq_stage)
			STG_KNOCK: sq_pending = CMD_READID;
			STG_INIT:  sq_pending = CMD_SETUP;
			STG_WAIT:  sq_pending = CMD_STATUS;
			STG_DATA:  sq_pending = CMD_READDATA;
			default:   return CMD_NONE;
		endcase
		return sq_pending;
	endfunction

	function automatic void complete_command(input logic ok, input logic [DATA_W-1:0] data);
		cmd_t done;
		done = sq_pending;
		sq_pending = CMD_NONE;
		case (done)
			CMD_READID: begin
				if (ok && data[7:0] == cf_chip_id) begin
					sq_stage = STG_INIT;
					sq_hold  = HOLD_INIT;
					sq_comm  = 1'b0;
				end else begin
					sq_stage = STG_UNINIT;
					sq_comm  = 1'b1;
				end
			end
			CMD_SETUP: begin
				if (ok) begin
					sq_stage = STG_WAIT;
					sq_hold  = HOLD_STATUS;
					sq_retry = '0;
					sq_comm  = 1'b0;
				end else begin
					sq_stage = STG_UNINIT;
					sq_hold  = HOLD_INIT;
					sq_comm  = 1'b1;
				end
			end
			CMD_STATUS: begin
				bump_retry();
				if (ok && data[7:0] == cf_ready) begin
					sq_stage = STG_DATA;
					sq_hold  = '0;
					sq_retry = '0;
				end else begin
					sq_hold = HOLD_STATUS;
					if (sq_retry > RETRY_LIMIT) begin
						sq_stage = STG_KNOCK;
						sq_retry = '0;
						reknocks++;
					end
				end
			end
			CMD_READDATA: begin
				if (ok) begin
					latch_sample(data);
					sq_retry = '0;
					sq_comm  = 1'b0;
					sample_reads++;
				end else begin
					bump_retry();
					sq_comm = 1'b1;
				end
				if (sq_retry > RETRY_LIMIT) begin
					sq_stage = STG_INIT;
					sq_hold  = HOLD_INIT;
				end else begin
					sq_stage = STG_WAIT;
					sq_hold  = cf_hold;
				end
				sq_retry = '0;
			end
			default: ;
		endcase
	endfunction

	// Advance the mirror by one accepted request and queue the result it causes
	function automatic void advance_sequencer(input logic [REQ_TYPE_W-1:0] kind, input logic ok,
		input logic [DATA_W-1:0] data);
		poll_result_t r;
		cmd_t issued;
		issued = CMD_NONE;
		case (kind)
			REQ_TICK: if (sq_hold != 0) sq_hold = sq_hold - 1'b1;
			REQ_POLL: issued = issue_poll();
			REQ_RESP: if (sq_pending != CMD_NONE) complete_command(ok, data);
			default: ;
		endcase
		r.cmd     = issued;
		r.stage   = sq_stage;
		r.press   = sq_press;
		r.press10 = PRESS10_W'(sq_press / 10);
		r.temp    = sq_temp;
		r.comm    = sq_comm;
		r.terr    = sq_terr;
		r.perr    = sq_perr;
		predicted_results.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Data builders
	// ------------------------------------------------------------------
	function automatic logic [DATA_W-1:0] rand48();
		return DATA_W'({$urandom, $urandom});
	endfunction

	function automatic logic [DATA_W-1:0] low_byte_word(input logic [BYTE_W-1:0] b);
		logic [DATA_W-1:0] d;
		d = rand48();
		d[7:0] = b;
		return d;
	endfunction

	function automatic logic [23:0] temp_raw(input int t, input int frac);
		int raw;
		raw = t * 6554 + frac;
		if (raw > 'hFFFFFF)
			raw = 'hFFFFFF;
		return 24'(raw);
	endfunction

	function automatic logic [DATA_W-1:0] make_word(input logic [PRESS_W-1:0] p,
		input logic [23:0] traw);
		return {traw, p, 6'($urandom)};
	endfunction

	// Data read word: a mix of in-window, random and extreme pressure and temperature
	function automatic logic [DATA_W-1:0] sample_word();
		logic [23:0] praw, traw;
		int lo, hi;
		case ($urandom_range(0, 3))
			0: praw = (cf_pmin <= cf_pmax)
				? {PRESS_W'($urandom_range(cf_pmax, cf_pmin)), 6'($urandom)} : 24'($urandom);
			3: praw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
			default: praw = 24'($urandom);
		endcase
		lo = (cf_tmin < 0) ? 0 : cf_tmin;
		hi = (cf_tmax > 2559) ? 2559 : cf_tmax;
		case ($urandom_range(0, 3))
			0: traw = (lo <= hi) ? temp_raw($urandom_range(hi, lo), $urandom_range(0, 6553))
				: 24'($urandom);
			3: traw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
			default: traw = 24'($urandom);
		endcase
		return {traw, praw};
	endfunction

	// ------------------------------------------------------------------
	// Request driver, register writes, drain
	// ------------------------------------------------------------------

	// Drive one request at the falling edge, hold it until accepted, then predict
	task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input logic ok,
		input logic [DATA_W-1:0] data);
		if (gaps_on && burst_left == 0) begin
			// drop valid for a random gap, with junk on the payload
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				req_ch.valid     <= 1'b0;
				req_ch.req_type  <= REQ_TYPE_W'($urandom);
				req_ch.bus_ok    <= 1'($urandom);
				req_ch.read_data <= rand48();
			end
			burst_left = $urandom_range(1, 24);
		end
		if (gaps_on)
			burst_left--;
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.bus_ok    <= ok;
		req_ch.read_data <= data;
		forever begin
			@(posedge clk);
			if (req_ch.ready)
				break;
		end
		requests_sent++;
		advance_sequencer(kind, ok, data);
	endtask

	// Lower valid and wait until every predicted result has come back
	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_CHIP_ID:   cf_chip_id = value[7:0];
			CFG_READY:     cf_ready   = value[7:0];
			CFG_PRESS_MIN: cf_pmin    = value[PRESS_W-1:0];
			CFG_PRESS_MAX: cf_pmax    = value[PRESS_W-1:0];
			CFG_TEMP_MIN:  cf_tmin    = value[TLIM_W-1:0];
			CFG_TEMP_MAX:  cf_tmax    = value[TLIM_W-1:0];
			CFG_HOLD:      cf_hold    = value[7:0];
			CFG_CLAMP:     cf_clamp   = value[0];
			default: ;
		endcase
	endtask

	task automatic program_all(input logic [7:0] chip, input logic [7:0] rdy,
		input logic [PRESS_W-1:0] pmin, input logic [PRESS_W-1:0] pmax,
		input logic [TLIM_W-1:0] tmin, input logic [TLIM_W-1:0] tmax,
		input logic [7:0] hold, input logic clamp);
		write_reg(CFG_CHIP_ID, CFG_W'(chip));
		write_reg(CFG_READY, CFG_W'(rdy));
		write_reg(CFG_PRESS_MIN, CFG_W'(pmin));
		write_reg(CFG_PRESS_MAX, CFG_W'(pmax));
		write_reg(CFG_TEMP_MIN, CFG_W'(tmin));
		write_reg(CFG_TEMP_MAX, CFG_W'(tmax));
		write_reg(CFG_HOLD, CFG_W'(hold));
		write_reg(CFG_CLAMP, CFG_W'(clamp));
	endtask

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------
	task automatic tick_out();
		while (sq_hold != 0)
			send_request(REQ_TICK, 1'($urandom), rand48());
	endtask

	// One step of a clean bring-up: answer what is outstanding, else count down, else poll
	task automatic send_good_step();
		logic [DATA_W-1:0] d;
		if (sq_pending != CMD_NONE) begin
			d = rand48();
			case (sq_pending)
				CMD_READID:   d[7:0] = cf_chip_id;
				CMD_STATUS:   d[7:0] = cf_ready;
				CMD_READDATA: d = sample_word();
				default: ;
			endcase
			send_request(REQ_RESP, 1'b1, d);
		end else if (sq_stage != STG_UNINIT && sq_hold != 0) begin
			send_request(REQ_TICK, 1'($urandom), rand48());
		end else begin
			send_request(REQ_POLL, 1'($urandom), rand48());
		end
	endtask

	task automatic go_to(input logic [STAGE_W-1:0] target);
		while (!(sq_stage == target && sq_pending == CMD_NONE))
			send_good_step();
	endtask

	task automatic read_sample(input logic [DATA_W-1:0] word);
		go_to(STG_DATA);
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b1, word);
	endtask

	// Mostly well-formed sequences with random answers, plus some noise
	task automatic random_step();
		logic [DATA_W-1:0] d;
		logic ok;
		if ($urandom_range(0, 99) < noise_pct) begin
			send_request(REQ_TYPE_W'($urandom_range(0, 3)), 1'($urandom), rand48());
		end else if (sq_pending != CMD_NONE) begin
			ok = ($urandom_range(0, 99) < 85);
			d  = rand48();
			case (sq_pending)
				CMD_READID:   if ($urandom_range(0, 99) < 80) d[7:0] = cf_chip_id;
				CMD_STATUS:   if ($urandom_range(0, 99) < 60) d[7:0] = cf_ready;
				CMD_READDATA: d = sample_word();
				default: ;
			endcase
			send_request(REQ_RESP, ok, d);
		end else if (sq_stage != STG_UNINIT && sq_hold != 0
			&& $urandom_range(0, 99) < 92) begin
			send_request(REQ_TICK, 1'($urandom), rand48());
		end else begin
			send_request(REQ_POLL, 1'($urandom), rand48());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Stray requests, hold timer, outstanding command, failed ID, setup and data reads
	task automatic test_bring_up();
		send_request(REQ_RESP, 1'b1, '1);          // nothing outstanding: ignored
		send_request(REQ_TICK, 1'b0, '0);          // hold already zero
		send_request(REQ_RSVD, 1'b1, rand48());    // unused request type
		send_request(REQ_POLL, 1'b0, '0);          // bus init
		send_request(REQ_POLL, 1'b1, '1);          // hold still running
		tick_out();
		send_request(REQ_POLL, 1'b0, rand48());    // read ID
		send_request(REQ_POLL, 1'b0, rand48());    // command outstanding
		send_request(REQ_TICK, 1'b1, rand48());
		send_request(REQ_RESP, 1'b1, low_byte_word(cf_chip_id ^ 8'h01));
		// right ID but the bus failed
		go_to(STG_KNOCK);
		tick_out();
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b0, low_byte_word(cf_chip_id));
		// setup fails, then uninit ignores the hold it set
		go_to(STG_INIT);
		tick_out();
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b0, rand48());
		send_request(REQ_POLL, 1'b0, rand48());
		// status not ready, then ready byte on a failed read, then a failed data read
		go_to(STG_WAIT);
		tick_out();
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b1, low_byte_word(cf_ready ^ 8'h80));
		tick_out();
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b0, low_byte_word(cf_ready));
		go_to(STG_DATA);
		send_request(REQ_POLL, 1'b0, rand48());
		send_request(REQ_RESP, 1'b0, rand48());
		read_sample(make_word(18'd100000, temp_raw(250, 17)));
	endtask

	// Window edges, clamp off, widest windows and inverted windows
	task automatic test_data_windows();
		drain_requests();
		write_reg(CFG_HOLD, '0);
		read_sample('0);
		read_sample('1);
		read_sample(make_word(18'd30000, temp_raw(850, 6553)));
		read_sample(make_word(18'd29999, temp_raw(851, 0)));
		read_sample(make_word(18'd125000, temp_raw(0, 0)));
		read_sample(make_word(18'd125001, temp_raw(1000, 0)));
		drain_requests();
		write_reg(CFG_CLAMP, '0);
		read_sample('1);
		read_sample('0);
		read_sample(make_word(18'd200000, temp_raw(900, 3)));
		drain_requests();
		program_all(cf_chip_id, cf_ready, '0, '1, 12'h800, 12'h7FF, 8'd0, 1'b1);
		read_sample('1);
		read_sample('0);
		drain_requests();
		// min above max: the below-min test takes both sides
		write_reg(CFG_PRESS_MIN, CFG_W'(200000));
		write_reg(CFG_PRESS_MAX, CFG_W'(1000));
		write_reg(CFG_TEMP_MIN, CFG_W'(12'd2000));
		write_reg(CFG_TEMP_MAX, CFG_W'(12'd100));
		read_sample(make_word(18'd50000, temp_raw(500, 0)));
		read_sample(make_word(18'd210000, temp_raw(2100, 0)));
	endtask

	// More than the retry limit of not-ready status polls forces a re-knock
	task automatic test_status_retry();
		logic ok;
		drain_requests();
		write_reg(CFG_READY, '0);
		write_reg(CFG_CHIP_ID, CFG_W'(8'hFF));
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		while (sq_stage == STG_WAIT) begin
			tick_out();
			send_request(REQ_POLL, 1'b0, rand48());
			ok = 1'($urandom);
			send_request(REQ_RESP, ok,
				ok ? low_byte_word(8'($urandom_range(1, 255))) : low_byte_word(8'($urandom)));
		end
		go_to(STG_WAIT);
	endtask

	task automatic test_random();
		logic [PRESS_W-1:0] pmin;
		int tlo;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_requests();
			case (phase)
				0: program_all(RST_CHIP_ID, RST_READY, RST_PRESS_MIN, RST_PRESS_MAX,
					RST_TEMP_MIN, RST_TEMP_MAX, 8'd10, 1'b1);
				1: program_all(8'h00, 8'hFF, '0, '1, 12'h800, 12'h7FF, 8'd0, 1'b0);
				2: program_all(8'hFF, 8'h00, RST_PRESS_MIN, RST_PRESS_MAX,
					RST_TEMP_MIN, RST_TEMP_MAX, 8'hFF, 1'b1);
				default: begin
					pmin = PRESS_W'($urandom_range(0, 131071));
					tlo  = $urandom_range(0, 1200) - 400;
					program_all(8'($urandom), 8'($urandom), pmin,
						PRESS_W'($urandom_range(262143, pmin)), TLIM_W'(tlo),
						TLIM_W'(tlo + $urandom_range(0, 1500)), 8'($urandom_range(0, 30)),
						1'($urandom));
				end
			endcase
			gaps_on    = (phase % 2 == 1) || (phase == 4);
			stall_on   = (phase % 3 != 0);
			burst_left = 0;
			noise_pct  = (phase == 0) ? 5 : 15;
			repeat (PHASE_REQUESTS) random_step();
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what, input poll_result_t want,
		input poll_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH (%s) cycle %0d: expected cmd=%0d stage=%0d pa=%0d 10pa=%0d t=%0d ce=%b te=%b pe=%b, got cmd=%0d stage=%0d pa=%0d 10pa=%0d t=%0d ce=%b te=%b pe=%b",
				what, cycle_count, want.cmd, want.stage, want.press, want.press10, want.temp,
				want.comm, want.terr, want.perr, got.cmd, got.stage, got.press, got.press10,
				got.temp, got.comm, got.terr, got.perr);
	endtask

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		poll_result_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.cmd     = cmd_t'(res_ch.command);
			got.stage   = res_ch.stage;
			got.press   = res_ch.pressure_pa;
			got.press10 = res_ch.pressure_10pa;
			got.temp    = res_ch.temperature_tenths;
			got.comm    = res_ch.comm_error;
			got.terr    = res_ch.temp_range_error;
			got.perr    = res_ch.press_range_error;
			results_seen++;
			if (predicted_results.size() == 0) begin
				note_mismatch("no request pending", got, got);
			end else begin
				want = predicted_results.pop_front();
				if (got !== want)
					note_mismatch("field", want, got);
			end
		end
	end

	// Receiver: runs of ready broken by short stalls while stalling is on
	always @(negedge clk) begin
		if (!stall_on) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else if (run_left > 0) begin
			res_ch.ready <= 1'b1;
			run_left--;
		end else begin
			res_ch.ready <= 1'b1;
			stall_left = $urandom_range(1, 6);
			run_left   = $urandom_range(0, 12);
		end
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				predicted_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		// Hold every input at a known value, then reset once
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_TICK;
		req_ch.bus_ok    = 1'b0;
		req_ch.read_data = '0;
		res_ch.ready     = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_CHIP_ID;
		cfg_wdata        = '0;
		clear_sequencer();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_bring_up();
		test_data_windows();
		test_status_retry();
		test_random();
		drain_requests();

		if (predicted_results.size() != 0) begin
			$display("%0d predicted results never arrived", predicted_results.size());
			mismatch_count += predicted_results.size();
		end
		$display("ran %0d requests, checked %0d results, %0d sample reads, %0d re-knocks",
			requests_sent, results_seen, sample_reads, reknocks);
		$display("%0d register writes: defaults, window extremes, inverted windows, clamp on/off",
			reg_writes);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
